@@ design/decimal_chop_round_top_assert.svh @@
// Assertion macros shared by the decimal chop and round block
`ifndef DECIMAL_CHOP_ROUND_TOP_ASSERT_SVH
`define DECIMAL_CHOP_ROUND_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DCR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// next-cycle implication, checked outside reset
`define DCR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

@@ design/dcr_pkg.sv @@
// Types, constants and power-of-ten tables for the decimal chop and round block
`default_nettype none
package dcr_pkg;

	localparam int VAL_W  = 30;
	localparam int DIG_W  = 4;
	localparam int UNIT_W = 34;
	localparam int BIT_W  = 5;
	localparam int DATA_W = 40;

	localparam logic [VAL_W-1:0] RESULT_MAX = {VAL_W{1'b1}};
	localparam logic [DIG_W-1:0] DIGITS_TOP = 4'd10;

	localparam logic OP_CHOP  = 1'b0;
	localparam logic OP_ROUND = 1'b1;

	typedef struct packed {
		logic load;
		logic cnt_step;
		logic div_init;
		logic div_step;
		logic finish;
	} dcr_cmd_t;

	typedef struct packed {
		logic cnt_done;
		logic keep_ge;
		logic div_last;
	} dcr_stat_t;

	// 10^n for n up to 10; larger n returns 10^10, above any 30-bit value
	function automatic logic [UNIT_W-1:0] pow10(input logic [DIG_W-1:0] n);
		logic [UNIT_W-1:0] p;
		unique case (n)
			4'd0:    p = 34'd1;
			4'd1:    p = 34'd10;
			4'd2:    p = 34'd100;
			4'd3:    p = 34'd1000;
			4'd4:    p = 34'd10000;
			4'd5:    p = 34'd100000;
			4'd6:    p = 34'd1000000;
			4'd7:    p = 34'd10000000;
			4'd8:    p = 34'd100000000;
			4'd9:    p = 34'd1000000000;
			default: p = 34'd10000000000;
		endcase
		return p;
	endfunction

	// elaboration-time 10^n in 64 bits
	function automatic logic [63:0] pow10_wide(input int n);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < n; i++)
			p = p * 64'd10;
		return p;
	endfunction

endpackage
`default_nettype wire

@@ design/dcr_ctrl.sv @@
// Sequencer for digit count, remainder division and result hand-off
`default_nettype none
module dcr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output dcr_pkg::dcr_cmd_t      cmd,
	input  wire dcr_pkg::dcr_stat_t stat
);
	import dcr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_SETUP,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && s_tvalid;
		cmd.cnt_step = (state_q == ST_COUNT) && !stat.cnt_done;
		cmd.div_init = (state_q == ST_SETUP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.finish)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_COUNT;
				end
				ST_COUNT: begin
					if (stat.cnt_done)
						state_q <= stat.keep_ge ? ST_FIN : ST_SETUP;
				end
				ST_SETUP: state_q <= ST_DIV;
				ST_DIV: begin
					if (stat.div_last)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/dcr_dp.sv @@
// Datapath: input saturation, digit counter, bit-serial remainder, and chop or rounding
`default_nettype none
module dcr_dp #(
	parameter int MAX_DIGITS = 9
) (
	input  wire logic                      clk,
	input  wire logic                      in_op,
	input  wire logic [dcr_pkg::VAL_W-1:0] in_value,
	input  wire logic [dcr_pkg::DIG_W-1:0] in_keep,
	input  wire dcr_pkg::dcr_cmd_t         cmd,
	output dcr_pkg::dcr_stat_t             stat,
	output logic [dcr_pkg::VAL_W-1:0]      result_value,
	output logic [dcr_pkg::DIG_W-1:0]      digit_count
);
	import dcr_pkg::*;

	localparam logic [63:0] LIMIT = pow10_wide(MAX_DIGITS) - 64'd1;

	logic [VAL_W-1:0]  val_q;
	logic              op_q;
	logic [DIG_W-1:0]  keep_q;
	logic [DIG_W-1:0]  k_q;
	logic [DIG_W-1:0]  digits_q;
	logic [UNIT_W-1:0] unit_q;
	logic [VAL_W-1:0]  rem_q;
	logic [BIT_W-1:0]  bit_q;

	logic [VAL_W-1:0]  sat_val;
	logic [VAL_W:0]    shifted;
	logic              sub_ok;
	logic [UNIT_W-1:0] sub_res;
	logic [VAL_W-1:0]  base;
	logic              round_up;
	logic [UNIT_W:0]   sum;
	logic [VAL_W-1:0]  fin_val;

	assign sat_val = ({34'd0, in_value} > LIMIT) ? LIMIT[VAL_W-1:0] : in_value;

	assign stat.cnt_done = (k_q == DIGITS_TOP) || ({4'd0, val_q} < pow10(k_q));
	assign stat.keep_ge  = (keep_q >= digits_q);
	assign stat.div_last = (bit_q == '0);

	// restoring step: shift in the next value bit, subtract the unit if it fits
	assign shifted = {rem_q, val_q[bit_q]};
	assign sub_ok  = ({3'd0, shifted} >= unit_q);
	assign sub_res = {3'd0, shifted} - unit_q;

	assign base     = val_q - rem_q;
	assign round_up = (op_q == OP_ROUND) && ({3'd0, rem_q, 1'b0} >= unit_q);
	assign sum      = {5'd0, base} + {1'b0, unit_q};

	always_comb begin
		if (stat.keep_ge)
			fin_val = val_q;
		else if (!round_up)
			fin_val = base;
		else if (sum > {5'd0, RESULT_MAX})
			fin_val = RESULT_MAX;
		else
			fin_val = sum[VAL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q    <= sat_val;
			op_q     <= in_op;
			keep_q   <= in_keep;
			k_q      <= '0;
			digits_q <= '0;
		end
		if (cmd.cnt_step) begin
			k_q      <= k_q + 4'd1;
			digits_q <= k_q + 4'd1;
		end
		if (cmd.div_init) begin
			unit_q <= pow10(digits_q - keep_q);
			rem_q  <= '0;
			bit_q  <= BIT_W'(VAL_W - 1);
		end
		if (cmd.div_step) begin
			rem_q <= sub_ok ? sub_res[VAL_W-1:0] : shifted[VAL_W-1:0];
			bit_q <= bit_q - 5'd1;
		end
		if (cmd.finish) begin
			result_value <= fin_val;
			digit_count  <= digits_q;
		end
	end

endmodule
`default_nettype wire

@@ design/decimal_chop_round_top.sv @@
// m_tvalid rises after the digit count alone when nothing is cut, else after the division too.
// The digit counter runs first; a setup state then loads the unit, and the
// bit-serial remainder works through the 30 value bits, most significant first.
// One word in flight: the next word is taken once the result is registered and the
// sequencer is back in idle; while the output register is still full, the result waits.
// arst_n clears the sequencer and the output valid; data registers are not reset.
`default_nettype none
`include "decimal_chop_round_top_assert.svh"
module decimal_chop_round_top #(
	parameter int MAX_DIGITS = 9
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // value[29:0], keep_digits[33:30], zero pad
	input  wire logic [0:0]  s_tuser,  // op[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // result_value[29:0], digit_count[33:30], zero pad
);
	import dcr_pkg::*;

	dcr_cmd_t         cmd;
	dcr_stat_t        stat;
	logic [VAL_W-1:0] result_value;
	logic [DIG_W-1:0] digit_count;

	dcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	dcr_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk          (clk),
		.in_op        (s_tuser[0]),
		.in_value     (s_tdata[29:0]),
		.in_keep      (s_tdata[33:30]),
		.cmd          (cmd),
		.stat         (stat),
		.result_value (result_value),
		.digit_count  (digit_count)
	);

	assign m_tdata = {6'd0, digit_count, result_value};

	`DCR_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.finish, (!m_tvalid || m_tready))
	`DCR_ASSERT_NEXT(a_one_in_flight, clk, arst_n, (s_tvalid && s_tready), !s_tready)
	`DCR_ASSERT_NOW(a_zero_result, clk, arst_n, (m_tvalid && digit_count == '0), (result_value == '0))

endmodule
`default_nettype wire
